// ===== rtl/csu_pkg.sv =====
// Shared types, codes and defaults for the counting semaphore unit.
package csu_pkg;

    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 8;
    localparam int PID_W    = 5;
    localparam int INIT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int NEWH_W   = 5;

    localparam int CSU_NUM_SEMS    = 32;
    localparam int CSU_NUM_PROCS   = 32;
    localparam int CSU_COUNT_WIDTH = 16;

    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PID_WAITING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    requester_pid;
        logic [INIT_W-1:0]   initial_count;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NEWH_W-1:0]   new_handle;
        logic                blocked;
        logic                woken_valid;
        logic [PID_W-1:0]    woken_pid;
    } t_rsp;

endpackage

// ===== rtl/counting_semaphore_unit.sv =====
// Top level of the counting semaphore unit: handshake registers around the pool.
// One request beat is taken per clock cycle when the result side is not stalled;
// an accepted request is held in the input register, one pass of logic between
// it and the result register reads and updates a single semaphore entry and its
// wait list, and the result register presents the outcome on the output. A stall
// on the result side holds both registers. All state sits in
// flip-flops, so the block is ready straight out of reset with no clearing pass.
// Slots are allocated in ascending order and never freed; waiters are woken in
// the order in which they blocked.
module counting_semaphore_unit import csu_pkg::*; #(
    parameter int NUM_SEMS    = CSU_NUM_SEMS,
    parameter int NUM_PROCS   = CSU_NUM_PROCS,
    parameter int COUNT_WIDTH = CSU_COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [HANDLE_W-1:0]        i_handle,
    input  logic [PID_W-1:0]           i_requester_pid,
    input  logic signed [INIT_W-1:0]   i_initial_count,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [NEWH_W-1:0]          o_new_handle,
    output logic                       o_blocked,
    output logic                       o_woken_valid,
    output logic [PID_W-1:0]           o_woken_pid
);

    logic r_in_valid, r_out_valid;
    t_req r_in_req;
    t_rsp r_out_rsp;
    t_rsp core_rsp;
    logic advance, in_take;

    // The held request moves on whenever the result register is free or draining.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    csu_core #(
        .NUM_SEMS    (NUM_SEMS),
        .NUM_PROCS   (NUM_PROCS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_in_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req.mode          <= i_mode;
            r_in_req.handle        <= i_handle;
            r_in_req.requester_pid <= i_requester_pid;
            r_in_req.initial_count <= i_initial_count;
        end
        if (advance) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_rsp.status;
    assign o_new_handle  = r_out_rsp.new_handle;
    assign o_blocked     = r_out_rsp.blocked;
    assign o_woken_valid = r_out_rsp.woken_valid;
    assign o_woken_pid   = r_out_rsp.woken_pid;

    a_held_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_req))
        else $error("held request lost or changed while the result side stalled");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced request produced no result beat");

    a_wake_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_woken_valid |-> o_status == ST_OK && !o_blocked)
        else $error("wake reported together with an error or a block");

    a_block_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_blocked |-> o_status == ST_OK && o_new_handle == '0)
        else $error("block reported together with an error or a handle");

endmodule

// ===== rtl/csu_core.sv =====
// Semaphore pool state and the single-pass request logic.
module csu_core import csu_pkg::*; #(
    parameter int NUM_SEMS    = CSU_NUM_SEMS,
    parameter int NUM_PROCS   = CSU_NUM_PROCS,
    parameter int COUNT_WIDTH = CSU_COUNT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int SIDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PIDX_W = $clog2(NUM_PROCS);
    localparam int ALLOC_W = $clog2(NUM_SEMS + 1);
    localparam int CMP_W = HANDLE_W + 1;
    localparam int CW = COUNT_WIDTH;
    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (COUNT_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -(33'sd1 <<< (COUNT_WIDTH - 1));
    localparam logic [CW-1:0] CNT_MAX = {1'b0, {(CW - 1){1'b1}}};

    // Slots are handed out in order and never released, so the lowest free slot
    // is always the number of slots allocated so far.
    logic [ALLOC_W-1:0] r_alloc, n_alloc;
    logic [NUM_SEMS-1:0]  r_qne;
    logic [NUM_PROCS-1:0] r_pwait;
    logic [CW-1:0]        r_count [NUM_SEMS];
    logic [PIDX_W-1:0]    r_head  [NUM_SEMS];
    logic [PIDX_W-1:0]    r_tail  [NUM_SEMS];
    logic [PIDX_W-1:0]    r_next  [NUM_PROCS];

    logic [SIDX_W-1:0] h_idx, alloc_idx;
    logic [PIDX_W-1:0] pid_idx;
    logic              handle_ok, pid_ok;
    logic [CW-1:0]     cur_cnt;
    logic              cur_qne;
    logic [PIDX_W-1:0] cur_head, cur_tail, head_next;
    logic              cnt_le_zero;
    logic signed [32:0] init_ext, init_clamp;

    logic              cnt_we, qne_we, qne_wd, head_we, tail_we, next_we, pw_we, pw_wd;
    logic [SIDX_W-1:0] cnt_idx, qne_idx;
    logic [CW-1:0]     cnt_wd;
    logic [PIDX_W-1:0] head_wd, pw_idx;
    t_rsp              rsp;

    always_comb begin
        h_idx     = SIDX_W'(i_req.handle);
        alloc_idx = SIDX_W'(r_alloc);
        pid_idx   = PIDX_W'(i_req.requester_pid);
        handle_ok = {1'b0, i_req.handle} < CMP_W'(r_alloc);
        pid_ok    = (PIDX_W + PID_W)'(i_req.requester_pid) < (PIDX_W + PID_W)'(NUM_PROCS);
        cur_cnt   = r_count[h_idx];
        cur_qne   = r_qne[h_idx];
        cur_head  = r_head[h_idx];
        cur_tail  = r_tail[h_idx];
        head_next = r_next[cur_head];
        cnt_le_zero = cur_cnt[CW-1] || (cur_cnt == '0);

        init_ext = {{(33 - INIT_W){i_req.initial_count[INIT_W-1]}}, i_req.initial_count};
        if (init_ext > SAT_HI) begin
            init_clamp = SAT_HI;
        end else if (init_ext < SAT_LO) begin
            init_clamp = SAT_LO;
        end else begin
            init_clamp = init_ext;
        end
    end

    always_comb begin
        rsp      = '0;
        n_alloc  = r_alloc;
        cnt_we   = 1'b0;
        cnt_idx  = h_idx;
        cnt_wd   = cur_cnt;
        qne_we   = 1'b0;
        qne_idx  = h_idx;
        qne_wd   = 1'b0;
        head_we  = 1'b0;
        head_wd  = pid_idx;
        tail_we  = 1'b0;
        next_we  = 1'b0;
        pw_we    = 1'b0;
        pw_idx   = pid_idx;
        pw_wd    = 1'b0;
        rsp.status = ST_OK;

        unique case (i_req.mode)
            MODE_CREATE: begin
                if (r_alloc == ALLOC_W'(NUM_SEMS)) begin
                    rsp.status = ST_NO_FREE;
                end else begin
                    if (init_clamp != init_ext) begin
                        rsp.status = ST_SATURATED;
                    end
                    rsp.new_handle = NEWH_W'(r_alloc);
                    n_alloc = r_alloc + 1'b1;
                    cnt_we  = 1'b1;
                    cnt_idx = alloc_idx;
                    cnt_wd  = init_clamp[CW-1:0];
                    qne_we  = 1'b1;
                    qne_idx = alloc_idx;
                    qne_wd  = 1'b0;
                end
            end
            MODE_WAIT: begin
                if (!handle_ok || !pid_ok) begin
                    rsp.status = ST_BAD_HANDLE;
                end else if (r_pwait[pid_idx]) begin
                    rsp.status = ST_PID_WAITING;
                end else if (cnt_le_zero) begin
                    // Append to the tail of the list; an empty queue gets a new head.
                    if (cur_qne) begin
                        next_we = 1'b1;
                    end else begin
                        head_we = 1'b1;
                        qne_we  = 1'b1;
                        qne_wd  = 1'b1;
                    end
                    tail_we     = 1'b1;
                    pw_we       = 1'b1;
                    pw_wd       = 1'b1;
                    rsp.blocked = 1'b1;
                end else begin
                    cnt_we = 1'b1;
                    cnt_wd = cur_cnt - 1'b1;
                end
            end
            MODE_SIGNAL: begin
                if (!handle_ok) begin
                    rsp.status = ST_BAD_HANDLE;
                end else if (cur_cnt == CNT_MAX) begin
                    rsp.status = ST_SATURATED;
                end else if (!cur_cnt[CW-1] && cur_qne) begin
                    // The new unit goes straight to the oldest waiter; count unchanged.
                    if (cur_head == cur_tail) begin
                        qne_we = 1'b1;
                        qne_wd = 1'b0;
                    end else begin
                        head_we = 1'b1;
                        head_wd = head_next;
                    end
                    pw_we           = 1'b1;
                    pw_idx          = cur_head;
                    pw_wd           = 1'b0;
                    rsp.woken_valid = 1'b1;
                    rsp.woken_pid   = PID_W'(cur_head);
                end else begin
                    cnt_we = 1'b1;
                    cnt_wd = cur_cnt + 1'b1;
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_qne   <= '0;
            r_pwait <= '0;
        end else if (i_fire) begin
            r_alloc <= n_alloc;
            if (qne_we) begin
                r_qne[qne_idx] <= qne_wd;
            end
            if (pw_we) begin
                r_pwait[pw_idx] <= pw_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (cnt_we) begin
                r_count[cnt_idx] <= cnt_wd;
            end
            if (head_we) begin
                r_head[h_idx] <= head_wd;
            end
            if (tail_we) begin
                r_tail[h_idx] <= pid_idx;
            end
            if (next_we) begin
                r_next[cur_tail] <= pid_idx;
            end
        end
    end

    assign o_rsp = rsp;

endmodule

// ===== sim/semaphore_pool_monitor.sv =====
// Monitor for the counting semaphore unit: tracks the pool, predicts each reply and compares.
module semaphore_pool_monitor import csu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [PID_W-1:0]    i_requester_pid,
    input  logic [INIT_W-1:0]   i_initial_count,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [NEWH_W-1:0]   i_new_handle,
    input  logic                i_blocked,
    input  logic                i_woken_valid,
    input  logic [PID_W-1:0]    i_woken_pid,
    output int                  o_mismatches,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic             slot_taken    [CSU_NUM_SEMS];
    int               sem_level     [CSU_NUM_SEMS];
    logic             has_waiters   [CSU_NUM_SEMS];
    logic [PID_W-1:0] oldest_waiter [CSU_NUM_SEMS];
    logic [PID_W-1:0] newest_waiter [CSU_NUM_SEMS];
    logic [PID_W-1:0] waiter_link   [CSU_NUM_PROCS];
    logic             pid_parked    [CSU_NUM_PROCS];

    t_rsp expected_replies [$];
    int   mismatches = 0;

    // Applies one request to the tracked pool and returns the reply it must produce.
    function automatic t_rsp apply_to_pool(t_req r);
        t_rsp             rsp;
        int               level_max;
        int               level_min;
        int               init;
        int               slot;
        int               h;
        int               pid;
        logic [PID_W-1:0] wake;
        rsp = '0;
        rsp.status = ST_OK;
        level_max = (1 << (CSU_COUNT_WIDTH - 1)) - 1;
        level_min = -(1 << (CSU_COUNT_WIDTH - 1));
        init = int'($signed(r.initial_count));
        h = int'(r.handle);
        pid = int'(r.requester_pid);
        slot = CSU_NUM_SEMS;
        case (r.mode)
            MODE_CREATE: begin
                for (int s = CSU_NUM_SEMS - 1; s >= 0; s--)
                    if (!slot_taken[s]) slot = s;
                if (slot == CSU_NUM_SEMS) begin
                    rsp.status = ST_NO_FREE;
                end else begin
                    if (init > level_max) begin
                        init = level_max;
                        rsp.status = ST_SATURATED;
                    end
                    if (init < level_min) begin
                        init = level_min;
                        rsp.status = ST_SATURATED;
                    end
                    slot_taken[slot] = 1'b1;
                    sem_level[slot] = init;
                    has_waiters[slot] = 1'b0;
                    rsp.new_handle = slot[NEWH_W-1:0];
                end
            end
            MODE_WAIT, MODE_SIGNAL: begin
                if (h >= CSU_NUM_SEMS || !slot_taken[h]) begin
                    rsp.status = ST_BAD_HANDLE;
                end else if (r.mode == MODE_WAIT) begin
                    if (pid >= CSU_NUM_PROCS) begin
                        rsp.status = ST_BAD_HANDLE;
                    end else if (pid_parked[pid]) begin
                        rsp.status = ST_PID_WAITING;
                    end else if (sem_level[h] <= 0) begin
                        // Append to the tail of the wait list.
                        if (has_waiters[h]) begin
                            waiter_link[newest_waiter[h]] = r.requester_pid;
                        end else begin
                            oldest_waiter[h] = r.requester_pid;
                            has_waiters[h] = 1'b1;
                        end
                        newest_waiter[h] = r.requester_pid;
                        pid_parked[pid] = 1'b1;
                        rsp.blocked = 1'b1;
                    end else begin
                        sem_level[h]--;
                    end
                end else if (sem_level[h] >= level_max) begin
                    rsp.status = ST_SATURATED;
                end else begin
                    sem_level[h]++;
                    // The unit just released goes straight to the oldest waiter.
                    if (sem_level[h] > 0 && has_waiters[h]) begin
                        wake = oldest_waiter[h];
                        if (wake == newest_waiter[h])
                            has_waiters[h] = 1'b0;
                        else
                            oldest_waiter[h] = waiter_link[wake];
                        pid_parked[wake] = 1'b0;
                        rsp.woken_valid = 1'b1;
                        rsp.woken_pid = wake;
                        sem_level[h]--;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_req seen;
        if (!i_rst_n) begin
            for (int s = 0; s < CSU_NUM_SEMS; s++) begin
                slot_taken[s] = 1'b0;
                has_waiters[s] = 1'b0;
            end
            for (int p = 0; p < CSU_NUM_PROCS; p++) begin
                pid_parked[p] = 1'b0;
                waiter_link[p] = '0;
            end
            expected_replies.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("new_handle", want.new_handle, i_new_handle);
                    check_field("blocked", want.blocked, i_blocked);
                    check_field("woken_valid", want.woken_valid, i_woken_valid);
                    check_field("woken_pid", want.woken_pid, i_woken_pid);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                seen = {i_mode, i_handle, i_requester_pid, i_initial_count};
                expected_replies.push_back(apply_to_pool(seen));
            end
        end
        o_outstanding <= expected_replies.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== sim/counting_semaphore_unit_tb.sv =====
// Testbench top for the counting semaphore unit: clock, reset, request stimulus and verdict.
module counting_semaphore_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csu_pkg::*;

    // The fourth mode code does nothing in the unit.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req_beat = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [STATUS_W-1:0] rsp_status;
    logic [NEWH_W-1:0] rsp_new_handle;
    logic rsp_blocked;
    logic rsp_woken_valid;
    logic [PID_W-1:0] rsp_woken_pid;

    int mismatches;
    int outstanding;
    int burst_left = 0;
    int slots_made = 0;
    int stall_phase_left = 0;
    int stall_pct = 0;

    counting_semaphore_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_mode          (req_beat.mode),
        .i_handle        (req_beat.handle),
        .i_requester_pid (req_beat.requester_pid),
        .i_initial_count (req_beat.initial_count),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_status        (rsp_status),
        .o_new_handle    (rsp_new_handle),
        .o_blocked       (rsp_blocked),
        .o_woken_valid   (rsp_woken_valid),
        .o_woken_pid     (rsp_woken_pid)
    );

    semaphore_pool_monitor u_monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_mode          (req_beat.mode),
        .i_handle        (req_beat.handle),
        .i_requester_pid (req_beat.requester_pid),
        .i_initial_count (req_beat.initial_count),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_stall     (rsp_stall),
        .i_status        (rsp_status),
        .i_new_handle    (rsp_new_handle),
        .i_blocked       (rsp_blocked),
        .i_woken_valid   (rsp_woken_valid),
        .i_woken_pid     (rsp_woken_pid),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // The receiver moves between phases of no stalling, light, moderate and heavy stalling.
    always @(posedge clk) begin
        if (stall_phase_left == 0) begin
            stall_phase_left <= $urandom_range(20, 150);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
    end

    // Presents one request beat, inserting a random gap whenever a burst runs out,
    // and returns at the edge where the beat is taken.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input int handle,
                             input int pid, input int init);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        if (mode == MODE_CREATE && slots_made < CSU_NUM_SEMS) slots_made++;
        req_valid <= 1'b1;
        req_beat <= '{mode: mode, handle: handle[HANDLE_W-1:0],
                      requester_pid: pid[PID_W-1:0], initial_count: init[INIT_W-1:0]};
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slots 0 to 3 at the top of the range, the bottom, zero and one.
        send_beat(MODE_CREATE, 0, 0, 32767);
        send_beat(MODE_CREATE, 0, 0, -32768);
        send_beat(MODE_CREATE, 0, 0, 0);
        send_beat(MODE_CREATE, 0, 0, 1);
        send_beat(MODE_SIGNAL, 0, 0, 0);
        send_beat(MODE_WAIT, 0, 0, 0);
        send_beat(MODE_SIGNAL, 0, 0, 0);
        // Two waiters on an empty semaphore, a repeated wait, then both woken in order.
        send_beat(MODE_WAIT, 2, 31, 0);
        send_beat(MODE_WAIT, 2, 31, 0);
        send_beat(MODE_WAIT, 2, 5, 0);
        send_beat(MODE_WAIT, 1, 5, 0);
        send_beat(MODE_SIGNAL, 2, 0, 0);
        send_beat(MODE_SIGNAL, 2, 0, 0);
        send_beat(MODE_SIGNAL, 2, 0, 0);
        send_beat(MODE_WAIT, 3, 7, 0);
        // Handles beyond the pool and a slot not yet created.
        send_beat(MODE_WAIT, 255, 3, 0);
        send_beat(MODE_SIGNAL, 200, 0, 0);
        send_beat(MODE_WAIT, 31, 4, 0);
        send_beat(MODE_UNUSED, 8'h5A, 5'h15, 16'h1234);
        send_beat(MODE_WAIT, 1, 10, 0);
        send_beat(MODE_SIGNAL, 1, 0, 0);
        wait_for_results();

        for (int n = 0; n < 950; n++) begin
            int pick;
            int h;
            int init;
            if (n == 475) wait_for_results();
            pick = $urandom_range(0, 99);
            // Slots 0 and 1 sit at the extremes, so the busy traffic avoids them.
            h = $urandom_range(2, slots_made - 1);
            init = $urandom;
            if (pick < 6) begin
                if (slots_made < CSU_NUM_SEMS) init = int'($urandom_range(0, 6)) - 3;
                send_beat(MODE_CREATE, $urandom_range(0, 255), $urandom_range(0, 31), init);
            end else if (pick < 50) begin
                send_beat(MODE_WAIT, h, $urandom_range(0, 31), init);
            end else if (pick < 93) begin
                send_beat(MODE_SIGNAL, h, $urandom_range(0, 31), init);
            end else if (pick < 97) begin
                send_beat(pick[0] ? MODE_WAIT : MODE_SIGNAL, $urandom_range(0, 255),
                          $urandom_range(0, 31), init);
            end else begin
                send_beat(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 31), init);
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== counting_semaphore_unit.f =====
rtl/csu_pkg.sv
rtl/csu_core.sv
rtl/counting_semaphore_unit.sv
sim/semaphore_pool_monitor.sv
sim/counting_semaphore_unit_tb.sv
